[design/rna_structural_motif_scanner_core_macros.svh]
// assertion macros shared by the motif scanner rtl
`ifndef RNA_STRUCTURAL_MOTIF_SCANNER_CORE_MACROS_SVH
`define RNA_STRUCTURAL_MOTIF_SCANNER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RSMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsms check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RSMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsms check failed");

`endif

[design/rsms_pkg.sv]
// package: types, codes and helpers of the rna motif scanner
`timescale 1ns / 1ps
`default_nettype none

package rsms_pkg;

  localparam int DEF_MAX_PHRASES   = 16;
  localparam int DEF_MAX_WINDOW    = 32;
  localparam int DEF_POSITION_BITS = 16;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W   = 5;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = 5;
  localparam int BASE_W    = 4;
  localparam int OUT_POS_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHRASE_KINDS      = 3'd0,
    CFG_PHRASE_MASKS_LOW  = 3'd1,
    CFG_PHRASE_MASKS_HIGH = 3'd2,
    CFG_PHRASE_COUNT      = 3'd3,
    CFG_CHECK_PAIRING     = 3'd4,
    CFG_FIRST_HIT_ONLY    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_PAIR    = 2'd0,
    KIND_LEFT    = 2'd1,
    KIND_RIGHT   = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  localparam logic [BASE_W-1:0] NB_A = 4'd1;
  localparam logic [BASE_W-1:0] NB_C = 4'd2;
  localparam logic [BASE_W-1:0] NB_G = 4'd4;
  localparam logic [BASE_W-1:0] NB_U = 4'd8;

  typedef struct packed {
    kind_t             kind;
    logic [BASE_W-1:0] mask;
    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
    logic              active;
  } phrase_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             len_ok;
    logic             check_pairing;
    logic             first_hit_only;
  } motif_ctl_t;

  function automatic logic subset(input logic [BASE_W-1:0] base,
                                  input logic [BASE_W-1:0] mask);
    return (base & mask) == base;
  endfunction

  function automatic logic can_pair(input logic [BASE_W-1:0] a,
                                    input logic [BASE_W-1:0] b);
    return (a == NB_U && b == NB_A) || (a == NB_C && b == NB_G) ||
           (a == NB_G && b == NB_C) || (a == NB_A && b == NB_U) ||
           (a == NB_U && b == NB_G) || (a == NB_G && b == NB_U);
  endfunction

endpackage

`default_nettype wire

[design/rna_structural_motif_scanner_core.sv]
// top level of the rna stem-loop motif scanner
//
// bases enter on in_* (valid/ready), one transaction per base; in_last_base
// closes a sequence. results leave on out_* (valid/ready): one transaction
// per matching start position, and one on every last base, where
// out_end_of_sequence is set and out_matched tells whether that base hit.
// configuration goes through cfg_we/cfg_index/cfg_wdata, one register per
// cycle; the user must write it only while no transaction is in flight, as
// the block itself does not enforce this. a base accepted is registered in
// the window stage and its result in the result register. throughput:
// one base per cycle while the receiver takes results, set by the single
// registered pass through the parallel phrase checks to the result register.
// the motif decode is registered, so it updates in the cycle after the
// configuration register that a write changes.
// reset: registers take their reset values, the position count and hit flag
// clear, both channels empty; in_ready is low while rst_n is low.
// a stalled receiver holds the result register; one more base waits in the
// window stage, and bases that give no result pass it freely.
`timescale 1ns / 1ps
`default_nettype none
`include "rna_structural_motif_scanner_core_macros.svh"

module rna_structural_motif_scanner_core #(
  parameter int MAX_PHRASES   = rsms_pkg::DEF_MAX_PHRASES,
  parameter int MAX_WINDOW    = rsms_pkg::DEF_MAX_WINDOW,
  parameter int POSITION_BITS = rsms_pkg::DEF_POSITION_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rsms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsms_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rsms_pkg::BASE_W-1:0]    in_base_mask,
  input  wire logic                           in_last_base,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_matched,
  output logic [rsms_pkg::OUT_POS_W-1:0]      out_start_position,
  output logic                                out_end_of_sequence
);

  localparam int PB = POSITION_BITS;
  localparam int SW = (PB > rsms_pkg::OUT_POS_W) ? PB : rsms_pkg::OUT_POS_W;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  rsms_pkg::phrase_t    phrases [MAX_PHRASES];
  rsms_pkg::motif_ctl_t ctl;

  rsms_cfg #(
    .MAX_PHRASES (MAX_PHRASES),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .phrases   (phrases),
    .ctl       (ctl)
  );

  // window stage
  logic [rsms_pkg::BASE_W-1:0] window_r [MAX_WINDOW];
  logic                        s1_valid_r;
  logic                        s1_last_r;
  logic [PB-1:0]               s1_pos_r;
  logic [PB-1:0]               bases_seen_r;
  logic                        hit_found_r;
  logic                        in_acc;
  logic                        s1_go;

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      window_r[0] <= in_base_mask;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        window_r[i] <= window_r[i-1];
      end
      s1_last_r <= in_last_base;
      s1_pos_r  <= bases_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      bases_seen_r <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_last_base) begin
          bases_seen_r <= '0;
        end else if (bases_seen_r != POS_MAX) begin
          bases_seen_r <= bases_seen_r + PB'(1);
        end
      end
    end
  end

  // match and result selection
  logic          shape_ok;
  logic          pos_sat;
  logic [PB:0]   pos_plus;
  logic [PB:0]   start_diff;
  logic          in_reach;
  logic          s1_match;
  logic          s1_emit;
  logic [PB-1:0] s1_start;
  logic [SW-1:0] start_ext;
  logic          hit_found_nxt;

  rsms_match #(
    .MAX_PHRASES (MAX_PHRASES),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_match (
    .window        (window_r),
    .phrases       (phrases),
    .check_pairing (ctl.check_pairing),
    .shape_ok      (shape_ok)
  );

  assign pos_sat    = s1_pos_r == POS_MAX;
  assign pos_plus   = {1'b0, s1_pos_r} + (PB+1)'(1);
  assign start_diff = pos_plus - (PB+1)'(ctl.len);
  assign in_reach   = pos_sat || (pos_plus >= (PB+1)'(ctl.len));
  assign s1_match   = ctl.len_ok && in_reach && shape_ok &&
                      !(ctl.first_hit_only && hit_found_r);
  assign s1_emit    = s1_match || s1_last_r;
  assign s1_start   = pos_sat ? POS_MAX : start_diff[PB-1:0];
  assign start_ext  = SW'(s1_start);

  assign s1_go    = s1_valid_r && (!s1_emit || !out_valid || out_ready);
  assign in_ready = rst_n && (!s1_valid_r || s1_go);

  assign hit_found_nxt = s1_last_r ? 1'b0 : (hit_found_r || s1_match);

  // result register
  logic                           out_valid_r;
  logic                           out_matched_r;
  logic [rsms_pkg::OUT_POS_W-1:0] out_start_r;
  logic                           out_eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_found_r <= 1'b0;
    end else begin
      if (s1_go && s1_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        hit_found_r <= hit_found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_matched_r <= s1_match;
      out_start_r   <= s1_match ? start_ext[rsms_pkg::OUT_POS_W-1:0] : '0;
      out_eos_r     <= s1_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_matched         = out_matched_r;
  assign out_start_position  = out_start_r;
  assign out_end_of_sequence = out_eos_r;

  `RSMS_ASSERT_NOW(a_no_hit_after_first, s1_valid_r && ctl.first_hit_only && hit_found_r, !s1_match)
  `RSMS_ASSERT_NEXT(a_hit_cleared_on_last, s1_go && s1_last_r, !hit_found_r)
  `RSMS_ASSERT_NEXT(a_hit_recorded, s1_go && s1_match && !s1_last_r, hit_found_r)
  `RSMS_ASSERT_NOW(a_nohit_zero_start, out_valid_r && !out_matched_r, out_start_r == '0)
  `RSMS_ASSERT_NEXT(a_stall_keeps_stage, s1_valid_r && s1_emit && out_valid_r && !out_ready, s1_valid_r)

endmodule

`default_nettype wire

[design/rsms_cfg.sv]
// configuration registers and registered motif decode
`timescale 1ns / 1ps
`default_nettype none

module rsms_cfg #(
  parameter int MAX_PHRASES = rsms_pkg::DEF_MAX_PHRASES,
  parameter int MAX_WINDOW  = rsms_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rsms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsms_pkg::CFG_W-1:0]     cfg_wdata,
  output rsms_pkg::phrase_t                   phrases [MAX_PHRASES],
  output rsms_pkg::motif_ctl_t                ctl
);

  logic [rsms_pkg::CFG_W-1:0]   kinds_r;
  logic [rsms_pkg::CFG_W-1:0]   masks_low_r;
  logic [rsms_pkg::CFG_W-1:0]   masks_high_r;
  logic [rsms_pkg::COUNT_W-1:0] count_r;
  logic                         check_pairing_r;
  logic                         first_hit_only_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kinds_r          <= '0;
      masks_low_r      <= '0;
      masks_high_r     <= '0;
      count_r          <= '0;
      check_pairing_r  <= 1'b1;
      first_hit_only_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsms_pkg::CFG_PHRASE_KINDS:      kinds_r          <= cfg_wdata;
        rsms_pkg::CFG_PHRASE_MASKS_LOW:  masks_low_r      <= cfg_wdata;
        rsms_pkg::CFG_PHRASE_MASKS_HIGH: masks_high_r     <= cfg_wdata;
        rsms_pkg::CFG_PHRASE_COUNT:      count_r          <= cfg_wdata[rsms_pkg::COUNT_W-1:0];
        rsms_pkg::CFG_CHECK_PAIRING:     check_pairing_r  <= cfg_wdata[0];
        rsms_pkg::CFG_FIRST_HIT_ONLY:    first_hit_only_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // motif decode
  logic [rsms_pkg::COUNT_W-1:0] used;
  rsms_pkg::kind_t              kind      [MAX_PHRASES];
  logic [rsms_pkg::BASE_W-1:0]  mask      [MAX_PHRASES];
  logic [MAX_PHRASES-1:0]       active;
  logic [MAX_PHRASES-1:0]       takes_left;
  logic [MAX_PHRASES-1:0]       takes_right;
  logic [MAX_PHRASES-1:0]       is_pair;
  logic [rsms_pkg::LEN_W-1:0]   left_cnt  [MAX_PHRASES];
  logic [rsms_pkg::LEN_W-1:0]   right_cnt [MAX_PHRASES];
  logic [rsms_pkg::LEN_W-1:0]   len;
  rsms_pkg::phrase_t            phrases_nxt [MAX_PHRASES];
  rsms_pkg::motif_ctl_t         ctl_nxt;
  rsms_pkg::phrase_t            phrases_r [MAX_PHRASES];
  rsms_pkg::motif_ctl_t         ctl_r;

  assign used = (count_r > rsms_pkg::COUNT_W'(MAX_PHRASES)) ?
                rsms_pkg::COUNT_W'(MAX_PHRASES) : count_r;

  for (genvar g = 0; g < MAX_PHRASES; g++) begin : g_field
    assign kind[g] = rsms_pkg::kind_t'(kinds_r[2*g +: 2]);
    if (g < 8) begin : g_low
      assign mask[g] = masks_low_r[4*g +: 4];
    end else begin : g_high
      assign mask[g] = masks_high_r[4*(g-8) +: 4];
    end
    assign active[g]      = rsms_pkg::COUNT_W'(g) < used;
    assign is_pair[g]     = active[g] && (kind[g] == rsms_pkg::KIND_PAIR);
    assign takes_left[g]  = active[g] &&
                            (kind[g] == rsms_pkg::KIND_PAIR || kind[g] == rsms_pkg::KIND_LEFT);
    assign takes_right[g] = active[g] &&
                            (kind[g] == rsms_pkg::KIND_PAIR || kind[g] == rsms_pkg::KIND_RIGHT);
  end

  // bases consumed from each end ahead of every phrase, and the motif length
  always_comb begin
    len = '0;
    for (int i = 0; i < MAX_PHRASES; i++) begin
      left_cnt[i]  = '0;
      right_cnt[i] = '0;
      for (int j = 0; j < MAX_PHRASES; j++) begin
        if (j < i) begin
          left_cnt[i]  = left_cnt[i] + rsms_pkg::LEN_W'(takes_left[j]);
          right_cnt[i] = right_cnt[i] + rsms_pkg::LEN_W'(takes_right[j]);
        end
      end
      len = len + rsms_pkg::LEN_W'(active[i]) + rsms_pkg::LEN_W'(is_pair[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PHRASES; i++) begin
      phrases_nxt[i].kind      = kind[i];
      phrases_nxt[i].mask      = mask[i];
      phrases_nxt[i].left_idx  = rsms_pkg::IDX_W'(len - rsms_pkg::LEN_W'(1) - left_cnt[i]);
      phrases_nxt[i].right_idx = rsms_pkg::IDX_W'(right_cnt[i]);
      phrases_nxt[i].active    = active[i];
    end
    ctl_nxt.len            = len;
    ctl_nxt.len_ok         = len <= rsms_pkg::LEN_W'(MAX_WINDOW);
    ctl_nxt.check_pairing  = check_pairing_r;
    ctl_nxt.first_hit_only = first_hit_only_r;
  end

  always_ff @(posedge clk) begin
    phrases_r <= phrases_nxt;
    ctl_r     <= ctl_nxt;
  end

  assign phrases = phrases_r;
  assign ctl     = ctl_r;

endmodule

`default_nettype wire

[design/rsms_match.sv]
// parallel phrase checks of the motif on the base window
`timescale 1ns / 1ps
`default_nettype none

module rsms_match #(
  parameter int MAX_PHRASES = rsms_pkg::DEF_MAX_PHRASES,
  parameter int MAX_WINDOW  = rsms_pkg::DEF_MAX_WINDOW
) (
  input  wire logic [rsms_pkg::BASE_W-1:0] window [MAX_WINDOW],
  input  wire rsms_pkg::phrase_t           phrases [MAX_PHRASES],
  input  wire logic                        check_pairing,
  output logic                             shape_ok
);

  localparam int IW = $clog2(MAX_WINDOW);

  logic [rsms_pkg::BASE_W-1:0] lb [MAX_PHRASES];
  logic [rsms_pkg::BASE_W-1:0] rb [MAX_PHRASES];
  logic [MAX_PHRASES-1:0]      ok;

  always_comb begin
    for (int i = 0; i < MAX_PHRASES; i++) begin
      lb[i] = window[phrases[i].left_idx[IW-1:0]];
      rb[i] = window[phrases[i].right_idx[IW-1:0]];
      if (!phrases[i].active) begin
        ok[i] = 1'b1;
      end else begin
        case (phrases[i].kind)
          rsms_pkg::KIND_PAIR:  ok[i] = rsms_pkg::subset(lb[i], phrases[i].mask) &&
                                        (!check_pairing || rsms_pkg::can_pair(lb[i], rb[i]));
          rsms_pkg::KIND_LEFT:  ok[i] = rsms_pkg::subset(lb[i], phrases[i].mask);
          rsms_pkg::KIND_RIGHT: ok[i] = rsms_pkg::subset(rb[i], phrases[i].mask);
          default:              ok[i] = 1'b0;
        endcase
      end
    end
  end

  assign shape_ok = &ok;

endmodule

`default_nettype wire
